// ===== sv/tcpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the two-class priority queue.
package tcpq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;

  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd60;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PENQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } result_t;

endpackage

// ===== sv/tcpq_ram.sv =====
`timescale 1ns / 1ps
// Entry storage: one write port and one registered read port.
module tcpq_ram #(
  parameter int DEPTH  = tcpq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [tcpq_pkg::VALUE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [tcpq_pkg::VALUE_W-1:0] rd_data
);

  logic [tcpq_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tcpq_seq.sv =====
`timescale 1ns / 1ps
// Command sequencer: ring pointers, threshold scan and one-slot-per-step shifting.
module tcpq_seq #(
  parameter int DEPTH = tcpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcpq_pkg::CMD_W-1:0]          cmd,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] value_in,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] threshold,
  output logic                                res_valid,
  output tcpq_pkg::result_t                   res,
  input  logic                                res_take
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN_RD  = 3'd1;
  localparam logic [2:0] ST_SCAN_CMP = 3'd2;
  localparam logic [2:0] ST_SHIFT_RD = 3'd3;
  localparam logic [2:0] ST_SHIFT_WR = 3'd4;
  localparam logic [2:0] ST_INS      = 3'd5;
  localparam logic [2:0] ST_DEQ      = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : AW'(p - 1'b1);
  endfunction

  logic [2:0]                    state, state_next;
  logic [AW-1:0]                 head, head_next;
  logic [CW-1:0]                 count, count_next;
  logic [AW-1:0]                 scan_ptr, scan_ptr_next;
  logic [CW-1:0]                 scan_idx, scan_idx_next;
  logic [AW-1:0]                 pos_ptr, pos_ptr_next;
  logic [AW-1:0]                 dst_ptr, dst_ptr_next;
  logic [tcpq_pkg::VALUE_W-1:0]  val, val_next;
  logic [tcpq_pkg::VALUE_W-1:0]  res_value, res_value_next;
  logic [tcpq_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic [SW-1:0]                 tail_sum;
  logic [AW-1:0]                 tail;
  logic                          full;
  logic                          empty;
  logic                          accept;
  logic signed [tcpq_pkg::VALUE_W-1:0] cmp_op;
  logic                          cmp_ge;
  logic [AW-1:0]                 dst_dec;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [tcpq_pkg::VALUE_W-1:0]  wr_data;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [tcpq_pkg::VALUE_W-1:0]  rd_data;

  tcpq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The tail slot is head plus count, wrapped once around the ring.
  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign accept   = in_valid && (state == ST_IDLE);
  // One threshold comparator serves the new value when idle and the read entry while scanning.
  assign cmp_op   = (state == ST_IDLE) ? value_in : $signed(rd_data);
  assign cmp_ge   = (cmp_op >= threshold);
  assign dst_dec  = ptr_dec(dst_ptr);

  assign in_stall      = (state != ST_IDLE);
  assign res_valid     = (state == ST_DONE);
  assign res.value     = res_value;
  assign res.status    = res_status;
  assign res.occupancy = tcpq_pkg::OCC_W'(count);

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    scan_ptr_next   = scan_ptr;
    scan_idx_next   = scan_idx;
    pos_ptr_next    = pos_ptr;
    dst_ptr_next    = dst_ptr;
    val_next        = val;
    res_value_next  = res_value;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = pos_ptr;
    wr_data         = val;
    rd_en           = 1'b0;
    rd_addr         = head;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          val_next        = value_in;
          res_value_next  = '0;
          res_status_next = tcpq_pkg::STATUS_OK;
          unique case (cmd) inside
            tcpq_pkg::CMD_ENQ,
            tcpq_pkg::CMD_PENQ: begin
              if (full) begin
                res_status_next = tcpq_pkg::STATUS_FULL;
                state_next      = ST_DONE;
              end else if (cmd == tcpq_pkg::CMD_PENQ && cmp_ge && !empty) begin
                scan_ptr_next = head;
                scan_idx_next = '0;
                state_next    = ST_SCAN_RD;
              end else begin
                pos_ptr_next = tail;
                state_next   = ST_INS;
              end
            end
            tcpq_pkg::CMD_DEQ: begin
              if (empty) begin
                res_status_next = tcpq_pkg::STATUS_EMPTY;
                state_next      = ST_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                state_next = ST_DEQ;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN_RD: begin
        rd_en      = 1'b1;
        rd_addr    = scan_ptr;
        state_next = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (cmp_ge) begin
          if (CW'(scan_idx + 1'b1) == count) begin
            // Every held entry is a priority entry: the new one goes last.
            pos_ptr_next = tail;
            state_next   = ST_INS;
          end else begin
            scan_idx_next = CW'(scan_idx + 1'b1);
            scan_ptr_next = ptr_inc(scan_ptr);
            state_next    = ST_SCAN_RD;
          end
        end else begin
          pos_ptr_next = scan_ptr;
          dst_ptr_next = tail;
          state_next   = ST_SHIFT_RD;
        end
      end

      ST_SHIFT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = dst_dec;
        state_next = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        wr_en        = 1'b1;
        wr_addr      = dst_ptr;
        wr_data      = rd_data;
        dst_ptr_next = dst_dec;
        state_next   = (dst_dec == pos_ptr) ? ST_INS : ST_SHIFT_RD;
      end

      ST_INS: begin
        wr_en      = 1'b1;
        wr_addr    = pos_ptr;
        wr_data    = val;
        count_next = CW'(count + 1'b1);
        state_next = ST_DONE;
      end

      ST_DEQ: begin
        res_value_next = rd_data;
        head_next      = ptr_inc(head);
        count_next     = CW'(count - 1'b1);
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr   <= scan_ptr_next;
    scan_idx   <= scan_idx_next;
    pos_ptr    <= pos_ptr_next;
    dst_ptr    <= dst_ptr_next;
    val        <= val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

endmodule

// ===== sv/two_class_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the two-class priority queue: threshold register and output register.
//
// Commands arrive on the input channel (in_valid, in_stall, cmd, value_in): enqueue at
// the tail, priority enqueue, or dequeue of the head. Each accepted beat yields exactly
// one result beat on the output channel (out_valid, out_stall, value_out, status,
// occupancy). The threshold is written through cfg_valid / cfg_ready / cfg_data; the
// user must write it only while the queue is idle, which the block does not enforce.
// cfg_ready is always high. Entries live in a single-port-read, single-port-write ring
// memory, and one sequencer touches one entry per memory access. A rejected or unused
// command goes straight to the done state, a plain enqueue through the insert state and
// a dequeue through the dequeue state. A priority enqueue of a value at or above the
// threshold into a non-empty queue first reads and compares the leading priority
// entries, plus the first ordinary entry when there is one, then moves the entries
// behind the gap back with a read and a write each, then inserts. The result beat
// appears at the edge that drops in_stall, so latency equals the stall time.
// Reset empties the queue, clears out_valid and loads the threshold with 60; no memory
// clearing pass is needed. While out_stall holds a result, the next command may still
// be processed, but its result is held back and in_stall stays high until the
// output register frees.
module two_class_priority_queue #(
  parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [tcpq_pkg::CMD_W-1:0]             cmd,
  input  logic signed [tcpq_pkg::VALUE_W-1:0]    value_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tcpq_pkg::VALUE_W-1:0]    value_out,
  output logic [tcpq_pkg::STATUS_W-1:0]          status,
  output logic [tcpq_pkg::OCC_W-1:0]             occupancy,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic signed [tcpq_pkg::VALUE_W-1:0]    cfg_data
);

  logic signed [tcpq_pkg::VALUE_W-1:0] threshold;
  logic                                res_valid;
  tcpq_pkg::result_t                   res;
  logic                                res_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tcpq_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  tcpq_seq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value_in  (value_in),
    .threshold (threshold),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The output register takes a ready result when it is empty or its beat is leaving.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      value_out <= res.value;
      status    <= res.status;
      occupancy <= res.occupancy;
    end
  end

endmodule

// ===== sim/queue_reply_checker.sv =====
`timescale 1ns / 1ps
// Reply checker for the two-class priority queue: tracks the queue contents and checks each reply.
module queue_reply_checker #(
  parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [tcpq_pkg::CMD_W-1:0]          cmd,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] value_in,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] value_out,
  input  logic [tcpq_pkg::STATUS_W-1:0]       status,
  input  logic [tcpq_pkg::OCC_W-1:0]          occupancy,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  replies_waiting
);

  logic signed [tcpq_pkg::VALUE_W-1:0] slots [QUEUE_DEPTH];
  int                                  fill;
  logic signed [tcpq_pkg::VALUE_W-1:0] threshold;
  tcpq_pkg::result_t                   queue_replies [$];

  initial begin
    mismatches = 0;
    replies_waiting = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one command to the tracked queue and returns the reply it must produce.
  function automatic tcpq_pkg::result_t apply_queue_cmd(
      input logic [tcpq_pkg::CMD_W-1:0] op,
      input logic signed [tcpq_pkg::VALUE_W-1:0] v);
    tcpq_pkg::result_t r;
    int                pos;
    int                k;
    r.value  = '0;
    r.status = tcpq_pkg::STATUS_OK;
    case (op) inside
      tcpq_pkg::CMD_ENQ, tcpq_pkg::CMD_PENQ: begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = tcpq_pkg::STATUS_FULL;
        end else begin
          pos = fill;
          // A priority value lands right behind the leading run of priority entries.
          if (op == tcpq_pkg::CMD_PENQ && v >= threshold) begin
            pos = 0;
            while (pos < fill && slots[pos] >= threshold) pos++;
          end
          for (k = fill; k > pos; k--) slots[k] = slots[k-1];
          slots[pos] = v;
          fill++;
        end
      end
      tcpq_pkg::CMD_DEQ: begin
        if (fill == 0) begin
          r.status = tcpq_pkg::STATUS_EMPTY;
        end else begin
          r.value = slots[0];
          for (k = 1; k < fill; k++) slots[k-1] = slots[k];
          fill--;
        end
      end
      default: ;
    endcase
    r.occupancy = tcpq_pkg::OCC_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    tcpq_pkg::result_t want;
    if (rst) begin
      fill = 0;
      threshold = tcpq_pkg::THRESHOLD_RESET;
      queue_replies.delete();
    end else begin
      // The reply side goes first: a reply never belongs to a command taken in the same cycle.
      if (out_valid && !out_stall) begin
        if (queue_replies.size() == 0) begin
          report_mismatch($sformatf("reply with none outstanding: value %0d status %0d occ %0d",
                                    value_out, status, occupancy));
        end else begin
          want = queue_replies.pop_front();
          if (value_out !== want.value)
            report_mismatch($sformatf("value_out %0d, expected %0d",
                                      value_out, $signed(want.value)));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      occupancy, want.occupancy));
        end
      end
      if (in_valid && !in_stall) queue_replies.push_back(apply_queue_cmd(cmd, value_in));
      if (cfg_valid && cfg_ready) threshold = cfg_data;
    end
    replies_waiting = queue_replies.size();
  end

endmodule

// ===== sim/tb_two_class_priority_queue.sv =====
`timescale 1ns / 1ps
// Testbench top of the two-class priority queue: clock, reset, traffic and verdict.
module tb_two_class_priority_queue;

  localparam int                         DEPTH           = tcpq_pkg::QUEUE_DEPTH_DEFAULT;
  localparam logic [tcpq_pkg::CMD_W-1:0] CMD_RESERVED    = 2'd3;
  localparam int                         IDLE_LIMIT      = 2000;
  localparam int                         HOLD_CYCLES     = 150;
  localparam int                         SETTLE_CYCLES   = 80;
  localparam int                         ITEMS_PER_PHASE = 145;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                                clk;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic [tcpq_pkg::CMD_W-1:0]          cmd       = '0;
  logic signed [tcpq_pkg::VALUE_W-1:0] value_in  = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [tcpq_pkg::VALUE_W-1:0] value_out;
  logic [tcpq_pkg::STATUS_W-1:0]       status;
  logic [tcpq_pkg::OCC_W-1:0]          occupancy;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic signed [tcpq_pkg::VALUE_W-1:0] cfg_data  = '0;
  int                                  mismatches;
  int                                  replies_waiting;

  logic signed [tcpq_pkg::VALUE_W-1:0] cur_threshold = tcpq_pkg::THRESHOLD_RESET;
  logic                                hold_req      = 1'b0;
  int                                  burst_left    = 1;
  int                                  enq_bias      = 55;
  int                                  idle_cycles   = 0;
  int                                  mode_cycles   = 0;
  stall_mode_t                         stall_mode    = STALL_NONE;

  two_class_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_top (.*);

  queue_reply_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offers one command beat and returns at a falling edge once it is taken and any gap ends.
  task automatic send_beat(input logic [tcpq_pkg::CMD_W-1:0] op,
                           input logic signed [tcpq_pkg::VALUE_W-1:0] v);
    int gap;
    in_valid = 1'b1;
    cmd      = op;
    value_in = v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        cmd      = tcpq_pkg::CMD_W'($urandom);
        value_in = $urandom;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic write_threshold(input logic signed [tcpq_pkg::VALUE_W-1:0] t);
    in_valid = 1'b0;
    while (replies_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = t;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_threshold = t;
  endtask

  // Values cluster around the threshold and the extremes, where the ordering decisions flip.
  function automatic logic signed [tcpq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5)) inside
      0, 1:    return cur_threshold + $signed($urandom_range(0, 4)) - 2;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3:       return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int count);
    int n;
    int r;
    for (n = 0; n < count; n++) begin
      // Shift between filling and draining so the queue swings between full and empty.
      if (n % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_bias = 30;
          1:       enq_bias = 55;
          default: enq_bias = 85;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3)                     send_beat(CMD_RESERVED, $urandom);
      else if (r < 3 + enq_bias / 2) send_beat(tcpq_pkg::CMD_ENQ, pick_value());
      else if (r < 3 + enq_bias)     send_beat(tcpq_pkg::CMD_PENQ, pick_value());
      else                           send_beat(tcpq_pkg::CMD_DEQ, $urandom);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else begin
        if (mode_cycles == 0) begin
          stall_mode  = stall_mode_t'($urandom_range(0, 3));
          mode_cycles = $urandom_range(20, 80);
        end
        mode_cycles--;
        case (stall_mode)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:     out_stall = (mode_cycles % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_beat(tcpq_pkg::CMD_DEQ, 32'sh0);
    // A priority value exactly at the threshold into an empty queue.
    send_beat(tcpq_pkg::CMD_PENQ, 32'sd60);
    send_beat(tcpq_pkg::CMD_ENQ, 32'sd59);
    send_beat(tcpq_pkg::CMD_PENQ, 32'sd59);
    send_beat(tcpq_pkg::CMD_PENQ, 32'sh7fffffff);
    send_beat(tcpq_pkg::CMD_ENQ, 32'sh80000000);
    send_beat(tcpq_pkg::CMD_PENQ, 32'sh80000000);
    send_beat(CMD_RESERVED, 32'sh5a5a5a5a);
    repeat (DEPTH - 6) send_beat(tcpq_pkg::CMD_ENQ, $urandom);
    send_beat(tcpq_pkg::CMD_ENQ, 32'sd1);
    send_beat(tcpq_pkg::CMD_PENQ, 32'sd100);
    repeat (3) send_beat(tcpq_pkg::CMD_DEQ, 32'sh0);
    run_phase(ITEMS_PER_PHASE);

    // Every entry counts as priority, so priority values always go to the tail.
    write_threshold(32'sh80000000);
    run_phase(ITEMS_PER_PHASE);

    write_threshold(32'sh7fffffff);
    hold_req = 1'b1;
    repeat (30) send_beat(tcpq_pkg::CMD_ENQ, pick_value());
    run_phase(ITEMS_PER_PHASE);

    write_threshold($urandom);
    run_phase(ITEMS_PER_PHASE);

    write_threshold(32'sd0);
    run_phase(ITEMS_PER_PHASE);

    in_valid = 1'b0;
    while (replies_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && replies_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcpq_pkg.sv
sv/tcpq_ram.sv
sv/tcpq_seq.sv
sv/two_class_priority_queue.sv
sim/queue_reply_checker.sv
sim/tb_two_class_priority_queue.sv
